>>> hw/rtl/sssg_pkg.sv
// Package for the sidelink sync sequence generator: widths, types and the
// elaboration-time builders for the phase, magnitude and m-sequence tables.
// No dependencies.
package sssg_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int N1_COUNT      = 168;
  localparam int SYM_LAST      = 61;
  localparam int MAG_W         = 15;
  localparam int OUT_W         = 16;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;

  // m-sequence tap masks for s~, c~ and z~
  localparam logic [4:0] TAPS_S = 5'h05;
  localparam logic [4:0] TAPS_C = 5'h09;
  localparam logic [4:0] TAPS_Z = 5'h17;

  typedef logic [63:0][MAG_W-1:0]   mag_tab_t;    // |cos(pi*k/126)| scaled
  typedef logic [1:0][63:0][7:0]    phase_tab_t;  // per root, per index: {quadrant, k}
  typedef logic [N1_COUNT-1:0][9:0] shift_tab_t;  // per N1: {m0, m1}

  // Derived identity fields held by the block
  typedef struct packed {
    logic       root_sel;  // 1: root 37
    logic [1:0] n2;
    logic [4:0] m0;
    logic [4:0] m1;
  } ident_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bt;
    v  = v_in;
    r  = '0;
    bt = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bt > v) bt = bt >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != 64'd0) begin
        if (v >= r + bt) begin
          v = v - (r + bt);
          r = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
        bt = bt >> 2;
      end
    end
    return r;
  endfunction

  // 6/sqrt(31) in Q30
  localparam logic [63:0] SCALE_Q30 = 64'd2 * isqrt64((64'd9 << 60) / 64'd31);

  function automatic logic [63:0] taylor_mul(input logic [63:0] term, input logic [63:0] t2);
    return (term * t2) >> 30;
  endfunction

  // Taylor series of cos in Q30, truncating at each term
  function automatic logic [63:0] cos_q30(input logic [63:0] th);
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    t2   = (th * th) >> 30;
    acc  = $signed(ONE_Q30);
    term = ONE_Q30;
    term = taylor_mul(term, t2) / 64'd2;   acc = acc - $signed(term);
    term = taylor_mul(term, t2) / 64'd12;  acc = acc + $signed(term);
    term = taylor_mul(term, t2) / 64'd30;  acc = acc - $signed(term);
    term = taylor_mul(term, t2) / 64'd56;  acc = acc + $signed(term);
    term = taylor_mul(term, t2) / 64'd90;  acc = acc - $signed(term);
    term = taylor_mul(term, t2) / 64'd132; acc = acc + $signed(term);
    term = taylor_mul(term, t2) / 64'd182; acc = acc - $signed(term);
    term = taylor_mul(term, t2) / 64'd240; acc = acc + $signed(term);
    term = taylor_mul(term, t2) / 64'd306; acc = acc - $signed(term);
    term = taylor_mul(term, t2) / 64'd380; acc = acc + $signed(term);
    term = taylor_mul(term, t2) / 64'd462; acc = acc - $signed(term);
    term = taylor_mul(term, t2) / 64'd552; acc = acc + $signed(term);
    if (acc < 0) acc = '0;
    return $unsigned(acc);
  endfunction

  function automatic logic [63:0] base_cos(input int k);
    logic [63:0] th;
    th = ((PI_Q60 / 64'd126) * 64'(k) + (64'd1 << 29)) >> 30;
    return cos_q30(th);
  endfunction

  // Q30 magnitude times scale, rounded half up to frac bits, saturated
  function automatic logic [MAG_W-1:0] to_mag(input logic [63:0] mag_q30, input int frac);
    logic [63:0] p;
    logic [63:0] r;
    int          sh;
    sh = 60 - frac;
    p  = mag_q30 * SCALE_Q30;
    r  = (p + (64'd1 << (sh - 1))) >> sh;
    if (r > 64'(MAG_MAX)) r = 64'(MAG_MAX);
    return r[MAG_W-1:0];
  endfunction

  function automatic mag_tab_t build_mag_tab(input int frac);
    mag_tab_t t;
    for (int k = 0; k < 64; k++) begin
      t[k] = to_mag(base_cos(k), frac);
    end
    return t;
  endfunction

  // Zadoff-Chu phase 2*p = 63*q + k, centre element skipped
  function automatic phase_tab_t build_phase_tab();
    phase_tab_t t;
    int         u;
    int         np;
    int         p;
    int         a;
    for (int rs = 0; rs < 2; rs++) begin
      u = (rs != 0) ? 37 : 26;
      for (int n = 0; n < 64; n++) begin
        np = (n <= 30) ? n : n + 1;
        p  = (u * np * (np + 1)) % 126;
        a  = 2 * p;
        if (n > SYM_LAST) t[rs][n] = '0;
        else t[rs][n] = {2'(a / 63), 6'(a % 63)};
      end
    end
    return t;
  endfunction

  function automatic shift_tab_t build_shift_tab();
    shift_tab_t t;
    int         qp;
    int         qq;
    int         mp;
    int         m0;
    int         m1;
    for (int n1 = 0; n1 < N1_COUNT; n1++) begin
      qp = n1 / 30;
      qq = (n1 + qp * (qp + 1) / 2) / 30;
      mp = n1 + qq * (qq + 1) / 2;
      m0 = mp % 31;
      m1 = (m0 + mp / 31 + 1) % 31;
      t[n1] = {5'(m0), 5'(m1)};
    end
    return t;
  endfunction

  function automatic logic [30:0] mseq(input logic [4:0] taps);
    logic [30:0] x;
    logic        b;
    x = 31'h10;
    for (int i = 0; i < 26; i++) begin
      b = 1'b0;
      for (int j = 0; j < 5; j++) begin
        if (taps[j]) b = b ^ x[i+j];
      end
      x[i+5] = b;
    end
    return x;
  endfunction

  // Sums stay below 62, so one conditional subtract suffices
  function automatic logic [4:0] mod31(input logic [5:0] x);
    logic [5:0] y;
    y = (x >= 6'd31) ? (x - 6'd31) : x;
    return y[4:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] apply_sign(input logic [MAG_W-1:0] mag,
                                                         input logic neg);
    logic [OUT_W-1:0] ext;
    ext = {1'b0, mag};
    return neg ? $signed(~ext + 16'd1) : $signed(ext);
  endfunction

endpackage

>>> hw/rtl/sidelink_sync_sequence_gen.sv
// The input transfer fills the index register, then the result register is loaded from
// it. Throughput: one item per cycle while res_ready stays high. An empty index register
// takes an item while a result waits, so one stalled result does not block the input.
// Synchronous reset empties both stages and sets the identity to 0 (root 26, N2 0).
module sidelink_sync_sequence_gen #(
  parameter int FRAC_BITS = sssg_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [8:0]          slss_id,
  input  logic                sym_valid,
  output logic                sym_ready,
  input  logic [5:0]          symbol_index,
  output logic                res_valid,
  input  logic                res_ready,
  output logic signed [15:0]  psss_re,
  output logic signed [15:0]  psss_im,
  output logic signed [15:0]  ssss_value
);
  import sssg_pkg::*;

  localparam mag_tab_t   MAG_TAB   = build_mag_tab(FRAC_BITS);
  localparam phase_tab_t PHASE_TAB = build_phase_tab();
  localparam shift_tab_t SHIFT_TAB = build_shift_tab();
  localparam logic [30:0] SEQ_S = mseq(TAPS_S);
  localparam logic [30:0] SEQ_C = mseq(TAPS_C);
  localparam logic [30:0] SEQ_Z = mseq(TAPS_Z);
  localparam logic [MAG_W-1:0] SSS_MAG = to_mag(ONE_Q30, FRAC_BITS);
  localparam logic signed [OUT_W-1:0] SSS_POS = apply_sign(SSS_MAG, 1'b0);
  localparam logic signed [OUT_W-1:0] SSS_NEG = apply_sign(SSS_MAG, 1'b1);
  localparam ident_t IDENT_RST = '{root_sel: 1'b0, n2: 2'd0,
                                   m0: SHIFT_TAB[0][9:5], m1: SHIFT_TAB[0][4:0]};

  ident_t      ident;
  ident_t      ident_next;
  logic        idx_valid;
  logic [5:0]  idx;
  logic        adv;

  logic [8:0]  n1_full;
  logic [7:0]  n1;

  logic [7:0]  phase;
  logic [1:0]  quad;
  logic [5:0]  k;
  logic [MAG_W-1:0] mag_c;
  logic [MAG_W-1:0] mag_s;
  logic        in_range;
  logic signed [OUT_W-1:0] re_next;
  logic signed [OUT_W-1:0] im_next;
  logic signed [OUT_W-1:0] sss_next;
  logic [4:0]  h;
  logic        sss_neg;

  assign cfg_ready = 1'b1;
  assign adv       = !res_valid || res_ready;
  assign sym_ready = !idx_valid || adv;

  // Identity split: N2 = id / 168 by range compare, N1 = remainder
  always_comb begin
    if (slss_id >= 9'(3 * N1_COUNT)) begin
      ident_next.n2 = 2'd3;
      n1_full       = slss_id - 9'(3 * N1_COUNT);
    end else if (slss_id >= 9'(2 * N1_COUNT)) begin
      ident_next.n2 = 2'd2;
      n1_full       = slss_id - 9'(2 * N1_COUNT);
    end else if (slss_id >= 9'(N1_COUNT)) begin
      ident_next.n2 = 2'd1;
      n1_full       = slss_id - 9'(N1_COUNT);
    end else begin
      ident_next.n2 = 2'd0;
      n1_full       = slss_id;
    end
    n1                  = n1_full[7:0];
    ident_next.root_sel = (slss_id >= 9'(N1_COUNT));
    ident_next.m0       = SHIFT_TAB[n1][9:5];
    ident_next.m1       = SHIFT_TAB[n1][4:0];
  end

  // Primary: quadrant folding of cos/sin of pi*k/126
  always_comb begin
    phase    = PHASE_TAB[ident.root_sel][idx];
    quad     = phase[7:6];
    k        = phase[5:0];
    mag_c    = MAG_TAB[k];
    mag_s    = MAG_TAB[6'd63 - k];
    in_range = (idx <= 6'(SYM_LAST));
    case (quad)
      2'd0: begin
        re_next = apply_sign(mag_c, 1'b0);
        im_next = apply_sign(mag_s, 1'b1);
      end
      2'd1: begin
        re_next = apply_sign(mag_s, 1'b1);
        im_next = apply_sign(mag_c, 1'b1);
      end
      2'd2: begin
        re_next = apply_sign(mag_c, 1'b1);
        im_next = apply_sign(mag_s, 1'b0);
      end
      default: begin
        re_next = apply_sign(mag_s, 1'b0);
        im_next = apply_sign(mag_c, 1'b0);
      end
    endcase
    if (!in_range) begin
      re_next = '0;
      im_next = '0;
    end
  end

  // Secondary: subframe-5 interleave of s~, c~ and z~
  always_comb begin
    h = idx[5:1];
    if (!idx[0]) begin
      sss_neg = SEQ_S[mod31({1'b0, h} + {1'b0, ident.m1})]
              ^ SEQ_C[mod31({1'b0, h} + {4'd0, ident.n2})];
    end else begin
      sss_neg = SEQ_S[mod31({1'b0, h} + {1'b0, ident.m0})]
              ^ SEQ_C[mod31({1'b0, h} + {4'd0, ident.n2} + 6'd3)]
              ^ SEQ_Z[mod31({1'b0, h} + {3'd0, ident.m1[2:0]})];
    end
    sss_next = in_range ? (sss_neg ? SSS_NEG : SSS_POS) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ident     <= IDENT_RST;
      idx_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) ident <= ident_next;
      if (sym_ready) idx_valid <= sym_valid;
      if (adv) res_valid <= idx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_valid && sym_ready) idx <= symbol_index;
    if (adv && idx_valid) begin
      psss_re    <= re_next;
      psss_im    <= im_next;
      ssss_value <= sss_next;
    end
  end

  // An item in the index register that moves on must show up as a result
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (idx_valid && adv) |=> res_valid)
    else $error("item lost between index and result register");

  // Secondary symbol is always the scaled amplitude with a sign, or zero
  a_sss_level: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (ssss_value == SSS_POS || ssss_value == SSS_NEG || ssss_value == '0))
    else $error("secondary symbol level out of set");

  // Root 37 exactly when N2 is non-zero
  a_ident: assert property (@(posedge clk) disable iff (rst)
    ident.root_sel == (ident.n2 != 2'd0))
    else $error("identity fields inconsistent");

endmodule
